@@ sv/bkl_pkg.sv @@
// Shared types, token codes and controller/datapath signal groups for the backward LZ unpacker.
`timescale 1ns / 1ps
`default_nettype none
package bkl_pkg;

	// Input beat: a packed stream word or a byte request.
	typedef struct packed {
		logic        kind;
		logic [31:0] word;
	} in_item_t;

	// Result beat returned for every request.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       need_word;
		logic       done_res;
		logic       check_ok;
	} out_item_t;

	// Values of the kind field.
	localparam logic KIND_WORD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	// Header phases.
	localparam logic [1:0] HDR_SIZE  = 2'd0;
	localparam logic [1:0] HDR_CHECK = 2'd1;
	localparam logic [1:0] HDR_BITS  = 2'd2;
	localparam logic [1:0] HDR_DONE  = 2'd3;

	// Token decoder phases.
	localparam logic [2:0] TOK_PREFIX  = 3'd0;
	localparam logic [2:0] TOK_SHORT   = 3'd1;
	localparam logic [2:0] TOK_KIND2   = 3'd2;
	localparam logic [2:0] TOK_LITLEN  = 3'd3;
	localparam logic [2:0] TOK_LENBYTE = 3'd4;
	localparam logic [2:0] TOK_DIST    = 3'd5;
	localparam logic [2:0] TOK_RUN     = 3'd6;

	// Marker bit placed at the top of a freshly loaded bit buffer.
	localparam logic [31:0] SENTINEL = 32'h8000_0000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic word_load;
		logic take_bit;
		logic dispatch;
		logic rd_issue;
		logic emit_lit;
		logic emit_copy;
		logic res_stall;
		logic res_empty;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hdr_done;
		logic done;
		logic bit_avail;
		logic want_zero;
		logic tok_run;
		logic run_copy;
	} stat_t;

endpackage
`default_nettype wire

@@ sv/bkl_chan_if.sv @@
// Valid/ready channel interface carrying one payload per beat.
`timescale 1ns / 1ps
`default_nettype none
interface bkl_chan_if #(
	parameter type PAYLOAD_T = logic
);
	logic     valid;
	logic     ready;
	PAYLOAD_T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/bkl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bkl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ sv/bkl_ctrl.sv @@
// Sequencing state machine: accepts beats, steps the bit reader and hands results out.
`timescale 1ns / 1ps
`default_nettype none
module bkl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_kind,
	output      logic          in_ready,
	output      logic          out_valid,
	input  wire logic          out_ready,
	input  wire bkl_pkg::stat_t stat,
	output      bkl_pkg::cmd_t  cmd
);
	import bkl_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_STEP = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_kind == KIND_WORD) begin
						cmd.word_load = 1'b1;
					end else if (!stat.hdr_done) begin
						cmd.res_stall = 1'b1;
						state_d       = S_OUT;
					end else if (stat.done) begin
						cmd.res_empty = 1'b1;
						state_d       = S_OUT;
					end else begin
						state_d = S_STEP;
					end
				end
			end
			S_STEP: begin
				if (!stat.want_zero) begin
					if (stat.bit_avail) begin
						cmd.take_bit = 1'b1;
					end else begin
						cmd.res_stall = 1'b1;
						state_d       = S_OUT;
					end
				end else if (!stat.tok_run) begin
					cmd.dispatch = 1'b1;
				end else if (stat.run_copy) begin
					cmd.rd_issue = 1'b1;
					state_d      = S_READ;
				end else begin
					cmd.emit_lit = 1'b1;
					state_d      = S_OUT;
				end
			end
			S_READ: begin
				cmd.emit_copy = 1'b1;
				state_d       = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

@@ sv/bkl_dp.sv @@
// Datapath: header registers, bit reader, token decoder, history memory and result registers.
`timescale 1ns / 1ps
`default_nettype none
module bkl_dp #(
	parameter int DISTANCE_BITS = 12
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bkl_pkg::cmd_t     cmd,
	output      bkl_pkg::stat_t    stat,
	input  wire logic [31:0]       word,
	output      bkl_pkg::out_item_t result
);
	import bkl_pkg::*;

	localparam int AW    = DISTANCE_BITS;
	localparam int WW    = $clog2(DISTANCE_BITS + 1);
	localparam int DEPTH = 1 << DISTANCE_BITS;

	logic [1:0]    hdr_q;
	logic [31:0]   left_q;
	logic [31:0]   chk_q;
	logic [31:0]   buf_q;
	logic          fresh_q;
	logic          fbit_q;
	logic [2:0]    tok_q;
	logic [AW-1:0] acc_q;
	logic [WW-1:0] want_q;
	logic [8:0]    run_q;
	logic          copy_q;
	logic [AW-1:0] dist_q;
	logic [7:0]    base_q;
	logic [AW-1:0] ptr_q;

	logic [7:0] res_byte_q;
	logic       res_valid_q;
	logic       res_need_q;
	out_item_t  out_q;

	logic          bit_in;
	logic [AW-1:0] acc_shift;
	logic [31:0]   left_dec;
	logic [8:0]    run_dec;
	logic [8:0]    run_count;
	logic [8:0]    run_clip;
	logic [7:0]    emit_byte;
	logic [7:0]    rd_data;
	logic [AW-1:0] rd_addr;
	logic          done_now;
	logic          emit;

	// Status towards the controller.
	assign done_now       = (hdr_q == HDR_DONE) && (left_q == 32'd0);
	assign stat.hdr_done  = (hdr_q == HDR_DONE);
	assign stat.done      = done_now;
	assign stat.bit_avail = fresh_q || (buf_q[31:1] != 31'd0);
	assign stat.want_zero = (want_q == '0);
	assign stat.tok_run   = (tok_q == TOK_RUN);
	assign stat.run_copy  = copy_q;

	// Bit reader: a pending fresh bit goes first, then the low bit of the buffer.
	assign bit_in    = fresh_q ? fbit_q : buf_q[0];
	assign acc_shift = {acc_q[AW-2:0], bit_in};

	// Run length, clipped to the bytes still to come.
	assign run_count = (tok_q == TOK_LITLEN)
		? ({1'b0, acc_q[7:0]} + {1'b0, base_q} + 9'd1)
		: ({1'b0, base_q} + 9'd1);
	assign run_clip  = ({23'd0, run_count} < left_q) ? run_count : left_q[8:0];

	// Byte production.
	assign emit      = cmd.emit_lit || cmd.emit_copy;
	assign emit_byte = cmd.emit_copy ? rd_data : acc_q[7:0];
	assign left_dec  = left_q - 32'd1;
	assign run_dec   = (run_q != 9'd0) ? run_q - 9'd1 : 9'd0;
	assign rd_addr   = ptr_q - dist_q;

	bkl_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (emit),
		.waddr(ptr_q),
		.wdata(emit_byte),
		.re   (cmd.rd_issue),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Decoder and header state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q   <= HDR_SIZE;
			left_q  <= '0;
			chk_q   <= '0;
			buf_q   <= '0;
			fresh_q <= 1'b0;
			fbit_q  <= 1'b0;
			tok_q   <= TOK_PREFIX;
			acc_q   <= '0;
			want_q  <= WW'(1);
			run_q   <= '0;
			copy_q  <= 1'b0;
			dist_q  <= '0;
			base_q  <= '0;
			ptr_q   <= '0;
		end else if (cmd.word_load) begin
			case (hdr_q)
				HDR_SIZE: begin
					left_q <= word;
					hdr_q  <= HDR_CHECK;
				end
				HDR_CHECK: begin
					chk_q <= word;
					hdr_q <= HDR_BITS;
				end
				HDR_BITS: begin
					buf_q  <= word;
					chk_q  <= chk_q ^ word;
					hdr_q  <= HDR_DONE;
					tok_q  <= TOK_PREFIX;
					want_q <= WW'(1);
					acc_q  <= '0;
				end
				default: begin
					// A word is taken only when the reader has run dry.
					if (left_q != 32'd0 && !fresh_q && buf_q[31:1] == 31'd0) begin
						chk_q   <= chk_q ^ word;
						fbit_q  <= word[0];
						buf_q   <= {1'b0, word[31:1]} | SENTINEL;
						fresh_q <= 1'b1;
					end
				end
			endcase
		end else if (cmd.take_bit) begin
			if (fresh_q) begin
				fresh_q <= 1'b0;
			end else begin
				buf_q <= {1'b0, buf_q[31:1]};
			end
			acc_q  <= acc_shift;
			want_q <= want_q - WW'(1);
		end else if (cmd.dispatch) begin
			acc_q <= '0;
			case (tok_q)
				TOK_PREFIX: begin
					if (acc_q != '0) begin
						tok_q  <= TOK_KIND2;
						want_q <= WW'(2);
					end else begin
						tok_q  <= TOK_SHORT;
						want_q <= WW'(1);
					end
				end
				TOK_SHORT: begin
					if (acc_q == '0) begin
						base_q <= 8'd0;
						tok_q  <= TOK_LITLEN;
						want_q <= WW'(3);
					end else begin
						base_q <= 8'd1;
						tok_q  <= TOK_DIST;
						want_q <= WW'(8);
					end
				end
				TOK_KIND2: begin
					if (acc_q == AW'(3)) begin
						base_q <= 8'd8;
						tok_q  <= TOK_LITLEN;
						want_q <= WW'(8);
					end else if (acc_q == AW'(2)) begin
						tok_q  <= TOK_LENBYTE;
						want_q <= WW'(8);
					end else begin
						// Short copies of three or four bytes.
						base_q <= {7'd1, acc_q[0]};
						tok_q  <= TOK_DIST;
						want_q <= acc_q[0] ? WW'(10) : WW'(9);
					end
				end
				TOK_LENBYTE: begin
					base_q <= acc_q[7:0];
					tok_q  <= TOK_DIST;
					want_q <= WW'(DISTANCE_BITS);
				end
				TOK_LITLEN: begin
					run_q  <= run_clip;
					copy_q <= 1'b0;
					tok_q  <= TOK_RUN;
					want_q <= WW'(8);
				end
				TOK_DIST: begin
					dist_q <= acc_q;
					run_q  <= run_clip;
					copy_q <= 1'b1;
					tok_q  <= TOK_RUN;
					want_q <= '0;
				end
				default: begin
					tok_q  <= TOK_PREFIX;
					want_q <= WW'(1);
				end
			endcase
		end else if (emit) begin
			ptr_q  <= ptr_q + AW'(1);
			left_q <= left_dec;
			run_q  <= run_dec;
			acc_q  <= '0;
			if (left_dec == 32'd0 || run_dec == 9'd0) begin
				tok_q  <= TOK_PREFIX;
				want_q <= WW'(1);
			end else begin
				tok_q  <= TOK_RUN;
				want_q <= copy_q ? WW'(0) : WW'(8);
			end
		end
	end

	// Pending result of the current request.
	always_ff @(posedge clk) begin
		if (emit) begin
			res_byte_q  <= emit_byte;
			res_valid_q <= 1'b1;
			res_need_q  <= 1'b0;
		end else if (cmd.res_stall) begin
			res_byte_q  <= 8'd0;
			res_valid_q <= 1'b0;
			res_need_q  <= 1'b1;
		end else if (cmd.res_empty) begin
			res_byte_q  <= 8'd0;
			res_valid_q <= 1'b0;
			res_need_q  <= 1'b0;
		end
	end

	// Output register; completion flags reflect the state after the step.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.data_byte  <= res_byte_q;
			out_q.byte_valid <= res_valid_q;
			out_q.need_word  <= res_need_q;
			out_q.done_res   <= done_now;
			out_q.check_ok   <= done_now && (chk_q == 32'd0);
		end
	end

	assign result = out_q;
endmodule
`default_nettype wire

@@ sv/backward_lz_bit_unpacker.sv @@
// Top level of the backward LZ bit unpacker.
//
//  Channel  Direction  Payload                                         Beat meaning
//  items    sink       kind, word                                      packed word or byte request
//  results  source     data_byte, byte_valid, need_word, done_res,     one beat per request
//                      check_ok
//
// A word beat gives no result. A request is accepted, then the reader takes each code bit,
// each token field is decoded, a copy issues its history read, the byte is produced and
// the output register is loaded.
// The pace is set by the reader, which takes one bit per cycle while bits are available, and by
// the single read port of the history RAM.
// Reset is asynchronous and clears all control state; the history RAM is not cleared.
// While a result waits on a stalled output the block still finishes one more request, then
// holds it and takes no further beats.
`timescale 1ns / 1ps
`default_nettype none
module backward_lz_bit_unpacker #(
	parameter int DISTANCE_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	bkl_chan_if.sink   items,
	bkl_chan_if.source results
);
	import bkl_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	bkl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_kind  (items.data.kind),
		.in_ready (items.ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bkl_dp #(
		.DISTANCE_BITS(DISTANCE_BITS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.stat  (stat),
		.word  (items.data.word),
		.result(results.data)
	);
endmodule
`default_nettype wire

@@ bench/backward_lz_bit_unpacker_test.sv @@
// Self-checking testbench for the backward LZ bit unpacker.
`timescale 1ns / 1ps
module backward_lz_bit_unpacker_test;
	import bkl_pkg::*;

	localparam int DIST_BITS = 12;
	localparam int HIST_DEPTH = 1 << DIST_BITS;
	localparam int CYCLE_LIMIT = 1_000_000;

	// Token prefix codes, first bit then the selector that follows it.
	localparam logic PFX_SHORT = 1'b0;
	localparam logic PFX_LONG = 1'b1;
	localparam logic SHORT_LIT = 1'b0;
	localparam logic SHORT_COPY = 1'b1;
	localparam logic [1:0] SEL_COPY3 = 2'd0;
	localparam logic [1:0] SEL_COPY4 = 2'd1;
	localparam logic [1:0] SEL_COPY_LONG = 2'd2;
	localparam logic [1:0] SEL_LIT_LONG = 2'd3;

	typedef enum {
		FORM_LIT_SHORT, FORM_COPY2, FORM_LIT_LONG, FORM_COPY3, FORM_COPY4, FORM_COPY_LONG
	} token_form_t;

	// Decoder model with its queue of owed result beats.
	class unpack_scoreboard_t;
		logic [1:0] hdr;
		logic [31:0] left;
		logic [31:0] check;
		logic [31:0] bits;
		logic [2:0] tok;
		logic [15:0] acc;
		int unsigned want;
		logic [8:0] run;
		bit run_copy;
		logic [DIST_BITS-1:0] copy_dist;
		logic [7:0] len_base;
		logic [7:0] hist [0:HIST_DEPTH-1];
		logic [DIST_BITS-1:0] hptr;
		bit fresh_pend;
		bit fresh_val;
		out_item_t owed[$];
		int errors;

		function new();
			hdr = HDR_SIZE;
			left = '0;
			check = '0;
			bits = '0;
			run = '0;
			run_copy = 1'b0;
			copy_dist = '0;
			len_base = '0;
			hptr = '0;
			fresh_pend = 1'b0;
			fresh_val = 1'b0;
			errors = 0;
			foreach (hist[i]) hist[i] = 8'h00;
			enter(TOK_PREFIX, 1);
		endfunction

		function void enter(logic [2:0] st, int unsigned n);
			tok = st;
			want = n;
			acc = '0;
		endfunction

		function void begin_run(int count, bit copy);
			run = 9'((count < left) ? count : left);
			run_copy = copy;
			enter(TOK_RUN, copy ? 0 : 8);
		endfunction

		function bit finished();
			return hdr == HDR_DONE && left == 0;
		endfunction

		// A word beat is absorbed during the header or when the buffer has run dry.
		function bit takes_word();
			return hdr != HDR_DONE || (left != 0 && !fresh_pend && bits[31:1] == 0);
		endfunction

		function out_item_t make(logic [7:0] b, bit v, bit need);
			out_item_t r;
			r.data_byte = b;
			r.byte_valid = v;
			r.need_word = need;
			r.done_res = finished();
			r.check_ok = finished() && check == 0;
			return r;
		endfunction

		function int take_bit();
			int b;
			if (fresh_pend) begin
				fresh_pend = 1'b0;
				return fresh_val;
			end
			if (bits[31:1] == 0)
				return -1;
			b = bits[0];
			bits = bits >> 1;
			return b;
		endfunction

		function void absorb_word(logic [31:0] w);
			case (hdr)
				HDR_SIZE: begin
					left = w;
					hdr = HDR_CHECK;
				end
				HDR_CHECK: begin
					check = w;
					hdr = HDR_BITS;
				end
				HDR_BITS: begin
					bits = w;
					check ^= w;
					hdr = HDR_DONE;
					enter(TOK_PREFIX, 1);
				end
				default: begin
					if (takes_word()) begin
						check ^= w;
						fresh_val = w[0];
						bits = {1'b1, w[31:1]};
						fresh_pend = 1'b1;
					end
				end
			endcase
		endfunction

		// Runs the decoder to a byte or to a bit shortage; header wait and finish return at once.
		function out_item_t serve_request();
			int b;
			logic [15:0] c;
			logic [7:0] byte_out;
			logic [DIST_BITS-1:0] rd_at;
			if (hdr != HDR_DONE)
				return make(8'h00, 1'b0, 1'b1);
			if (left == 0)
				return make(8'h00, 1'b0, 1'b0);
			forever begin
				while (want > 0) begin
					b = take_bit();
					if (b < 0)
						return make(8'h00, 1'b0, 1'b1);
					acc = {acc[14:0], b[0]};
					want--;
				end
				c = acc;
				case (tok)
					TOK_PREFIX: begin
						if (c[0] == PFX_LONG)
							enter(TOK_KIND2, 2);
						else
							enter(TOK_SHORT, 1);
					end
					TOK_SHORT: begin
						if (c[0] == SHORT_LIT) begin
							len_base = 8'd0;
							enter(TOK_LITLEN, 3);
						end else begin
							len_base = 8'd1;
							enter(TOK_DIST, 8);
						end
					end
					TOK_KIND2: begin
						if (c[1:0] == SEL_LIT_LONG) begin
							len_base = 8'd8;
							enter(TOK_LITLEN, 8);
						end else if (c[1:0] == SEL_COPY3 || c[1:0] == SEL_COPY4) begin
							len_base = c[7:0] + 8'd2;
							enter(TOK_DIST, c + 9);
						end else begin
							enter(TOK_LENBYTE, 8);
						end
					end
					TOK_LENBYTE: begin
						len_base = c[7:0];
						enter(TOK_DIST, DIST_BITS);
					end
					TOK_LITLEN: begin
						begin_run(int'(c) + int'(len_base) + 1, 1'b0);
					end
					TOK_DIST: begin
						copy_dist = c[DIST_BITS-1:0];
						begin_run(int'(len_base) + 1, 1'b1);
					end
					default: begin
						rd_at = hptr - copy_dist;
						byte_out = run_copy ? hist[rd_at] : c[7:0];
						hist[hptr] = byte_out;
						hptr++;
						left--;
						if (run > 0)
							run--;
						if (left == 0 || run == 0)
							enter(TOK_PREFIX, 1);
						else
							enter(TOK_RUN, run_copy ? 0 : 8);
						return make(byte_out, 1'b1, 1'b0);
					end
				endcase
			end
		endfunction

		function void note_input(in_item_t it);
			if (it.kind == KIND_WORD)
				absorb_word(it.word);
			else
				owed.push_back(serve_request());
		endfunction

		// Fields in order: byte, valid, need, done, ok.
		function void note_miss(string what, out_item_t want_r, out_item_t got);
			errors++;
			if (errors <= 10)
				$display("%s: expected %h %b %b %b %b, got %h %b %b %b %b",
					what, want_r.data_byte, want_r.byte_valid, want_r.need_word,
					want_r.done_res, want_r.check_ok, got.data_byte, got.byte_valid,
					got.need_word, got.done_res, got.check_ok);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want_r;
			if (owed.size() == 0) begin
				note_miss("unexpected result", '0, got);
				return;
			end
			want_r = owed.pop_front();
			if (got.data_byte !== want_r.data_byte || got.byte_valid !== want_r.byte_valid ||
				got.need_word !== want_r.need_word || got.done_res !== want_r.done_res ||
				got.check_ok !== want_r.check_ok)
				note_miss("result mismatch", want_r, got);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bkl_chan_if #(.PAYLOAD_T(in_item_t)) items_ch ();
	bkl_chan_if #(.PAYLOAD_T(out_item_t)) results_ch ();

	unpack_scoreboard_t sb = new();
	bit code_bits[$];
	logic [31:0] packed_words[$];
	int made;
	int target;
	int sent = 0;
	bit calm = 1'b0;
	bit tail = 1'b0;
	bit hold_req = 1'b0;
	int cycles = 0;

	backward_lz_bit_unpacker #(.DISTANCE_BITS(DIST_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch)
	);

	always #4 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("backward_lz_bit_unpacker regression: fail");
			$finish;
		end
	end

	function automatic void push_code(int unsigned v, int n);
		for (int i = n - 1; i >= 0; i--)
			code_bits.push_back(v[i]);
	endfunction

	function automatic int far_pick(int maxd);
		return $urandom_range(1, made < maxd ? made : maxd);
	endfunction

	// Appends one token and the literal bytes that will actually be read.
	function automatic void put_token(token_form_t form, int n, int d);
		int count;
		bit lit;
		lit = 1'b0;
		case (form)
			FORM_LIT_SHORT: begin
				push_code(PFX_SHORT, 1);
				push_code(SHORT_LIT, 1);
				push_code(n, 3);
				count = n + 1;
				lit = 1'b1;
			end
			FORM_COPY2: begin
				push_code(PFX_SHORT, 1);
				push_code(SHORT_COPY, 1);
				push_code(d, 8);
				count = 2;
			end
			FORM_LIT_LONG: begin
				push_code(PFX_LONG, 1);
				push_code(SEL_LIT_LONG, 2);
				push_code(n, 8);
				count = n + 9;
				lit = 1'b1;
			end
			FORM_COPY3: begin
				push_code(PFX_LONG, 1);
				push_code(SEL_COPY3, 2);
				push_code(d, 9);
				count = 3;
			end
			FORM_COPY4: begin
				push_code(PFX_LONG, 1);
				push_code(SEL_COPY4, 2);
				push_code(d, 10);
				count = 4;
			end
			default: begin
				push_code(PFX_LONG, 1);
				push_code(SEL_COPY_LONG, 2);
				push_code(n, 8);
				push_code(d, DIST_BITS);
				count = n + 1;
			end
		endcase
		if (count > target - made)
			count = target - made;
		if (lit)
			repeat (count) push_code($urandom_range(0, 255), 8);
		made += count;
	endfunction

	// Builds one packed stream: header words first, then the bit words in feed order.
	task automatic build_stream();
		bit far_done;
		bit zero_done;
		int pick;
		int total;
		int k;
		logic [31:0] first;
		logic [31:0] chk;
		logic [31:0] w;
		far_done = 1'b0;
		zero_done = 1'b0;
		made = 0;
		target = 1200 + $urandom_range(0, 100);
		// Extremes of the token forms first; the four-byte copy reaches back to the first byte.
		put_token(FORM_LIT_SHORT, 0, 0);
		put_token(FORM_LIT_SHORT, 7, 0);
		put_token(FORM_COPY2, 0, 1);
		put_token(FORM_LIT_LONG, 0, 0);
		put_token(FORM_COPY3, 0, 1);
		put_token(FORM_COPY4, 0, made);
		put_token(FORM_COPY_LONG, 0, 1);
		put_token(FORM_COPY_LONG, 255, 2);
		put_token(FORM_LIT_LONG, 255, 0);
		put_token(FORM_COPY2, 0, 255);
		put_token(FORM_COPY3, 0, 511);
		while (made < target) begin
			if (made >= HIST_DEPTH - 1 && !far_done) begin
				put_token(FORM_COPY_LONG, $urandom_range(0, 255), HIST_DEPTH - 1);
				far_done = 1'b1;
			end else if (made >= HIST_DEPTH && !zero_done) begin
				// Zero distance re-reads the slot written a full history ago.
				put_token(FORM_COPY_LONG, $urandom_range(0, 255), 0);
				zero_done = 1'b1;
			end else if (target - made <= 12) begin
				// The last literal run overshoots and must be clipped.
				put_token(FORM_LIT_LONG, $urandom_range(4, 255), 0);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 30)
					put_token(FORM_LIT_SHORT, $urandom_range(0, 7), 0);
				else if (pick < 42)
					put_token(FORM_COPY2, 0, far_pick(255));
				else if (pick < 52)
					put_token(FORM_LIT_LONG, ($urandom_range(0, 3) == 0) ?
						$urandom_range(0, 255) : $urandom_range(0, 15), 0);
				else if (pick < 62)
					put_token(FORM_COPY3, 0, far_pick(511));
				else if (pick < 74)
					put_token(FORM_COPY4, 0, far_pick(1023));
				else
					put_token(FORM_COPY_LONG, $urandom_range(0, 255), far_pick(HIST_DEPTH - 1));
			end
		end
		// The first buffer word carries k bits under its marker bit.
		total = code_bits.size();
		k = $urandom_range(0, total < 31 ? total : 31);
		first = 32'h1 << k;
		for (int j = 0; j < k; j++)
			first[j] = code_bits[j];
		if (k == 0 && $urandom_range(0, 1) == 1)
			first = '0;
		chk = first;
		for (int pos = k; pos < total; pos += 32) begin
			w = $urandom;
			for (int j = 0; j < 32; j++)
				if (pos + j < total)
					w[j] = code_bits[pos + j];
			packed_words.push_back(w);
			chk ^= w;
		end
		if ($urandom_range(0, 3) == 0)
			chk ^= 32'h1 << $urandom_range(0, 31);
		packed_words.push_front(first);
		packed_words.push_front(chk);
		packed_words.push_front(target);
	endtask

	// Offers one beat, idling first at random, and notes it once taken.
	task automatic send_item(input logic beat_kind, input logic [31:0] w);
		in_item_t it;
		it.kind = beat_kind;
		it.word = w;
		if (!calm && $urandom_range(0, 5) == 0) begin
			items_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.data <= it;
		do
			@(posedge clk);
		while (!(items_ch.valid && items_ch.ready));
		sb.note_input(it);
		sent++;
	endtask

	// Result side: checks each beat and stalls in bursts, once for a long stretch.
	initial begin : drain
		int stall_cnt;
		bit held;
		bit next_ready;
		stall_cnt = 0;
		held = 1'b0;
		results_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (results_ch.valid && results_ch.ready)
				sb.check_result(results_ch.data);
			if (hold_req && !held) begin
				held = 1'b1;
				stall_cnt = 300;
			end
			if (stall_cnt > 0) begin
				stall_cnt--;
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					stall_cnt = $urandom_range(1, 4);
			end
			results_ch.ready <= next_ready;
		end
	end

	// Stimulus: mostly feeds stream words when the decoder can take one, otherwise requests and the odd stray word.
	initial begin : stimulus
		int pick;
		items_ch.valid = 1'b0;
		items_ch.data = '0;
		build_stream();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Requests while the header is still arriving.
		send_item(KIND_REQUEST, $urandom);
		send_item(KIND_WORD, packed_words.pop_front());
		send_item(KIND_REQUEST, $urandom);
		while (!sb.finished() && sent < 40000) begin
			if (sb.hdr == HDR_DONE && sb.left < 150)
				tail = 1'b1;
			if (sent % 128 == 0)
				calm = tail || ($urandom_range(0, 3) == 0);
			if (sent >= 600)
				hold_req = 1'b1;
			if (sb.takes_word() && packed_words.size() != 0 && $urandom_range(0, 7) != 0) begin
				send_item(KIND_WORD, packed_words.pop_front());
			end else if (!sb.takes_word() && $urandom_range(0, 9) == 0) begin
				// A word the decoder has no room for is dropped unchecked.
				pick = $urandom_range(0, 3);
				send_item(KIND_WORD, (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom);
			end else begin
				send_item(KIND_REQUEST, $urandom);
			end
		end
		calm = 1'b1;
		// Requests and stray words once the whole size has been produced.
		for (int i = 0; i < 12; i++)
			send_item((i % 3 == 0) ? KIND_WORD : KIND_REQUEST, $urandom);
		items_ch.valid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (sb.errors == 0)
			$display("backward_lz_bit_unpacker regression: pass");
		else
			$display("backward_lz_bit_unpacker regression: fail");
		$finish;
	end
endmodule

@@ files.f @@
sv/bkl_pkg.sv
sv/bkl_chan_if.sv
sv/bkl_ram.sv
sv/bkl_ctrl.sv
sv/bkl_dp.sv
sv/backward_lz_bit_unpacker.sv
bench/backward_lz_bit_unpacker_test.sv
